// ===== hdl/upd_pkg.sv =====
package upd_pkg;

   localparam logic [7:0] ChPlus    = 8'h2B;
   localparam logic [7:0] ChPercent = 8'h25;
   localparam logic [7:0] ChSpace   = 8'h20;

   // escape phase codes
   localparam logic [1:0] PhIdle  = 2'd0;
   localparam logic [1:0] PhPct   = 2'd1;
   localparam logic [1:0] PhDigit = 2'd2;

   localparam int MaxBytes = 3;
   localparam int QDepth   = 2;
   localparam int QPtrW    = (QDepth > 1) ? $clog2(QDepth) : 1;
   localparam int QFillW   = $clog2(QDepth + 1);

   // one queue entry: the bytes that one input word produces
   typedef struct packed {
      logic [MaxBytes-1:0][7:0] bytes;
      logic [1:0]               count;
      logic                     last;
   } entry_type;

   typedef struct packed {
      logic empty;
      logic full;
   } q_status_type;

   function automatic logic is_hex(input logic [7:0] b);
      return (b >= 8'h30 && b <= 8'h39) ||
             (b >= 8'h41 && b <= 8'h46) ||
             (b >= 8'h61 && b <= 8'h66);
   endfunction

   function automatic logic [3:0] hex_value(input logic [7:0] b);
      logic [7:0] v;
      if (b <= 8'h39) begin
         v = b - 8'h30;
      end else begin
         v = 8'd10 + ((b | 8'h20) - 8'h61);
      end
      return v[3:0];
   endfunction

endpackage

// ===== hdl/upd_front.sv =====
module upd_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [7:0]            in_byte,
   input  logic                  in_last,
   input  upd_pkg::q_status_type q_status,
   output logic                  push,
   output upd_pkg::entry_type    push_entry
);

   logic [1:0] phase_ff, phase_in;
   logic [7:0] held_ff, held_in;
   logic       accept;
   logic       b_hex;

   upd_pkg::entry_type ent;

   assign in_ready = !q_status.full;
   assign accept   = in_valid && in_ready;
   assign b_hex    = upd_pkg::is_hex(in_byte);

   always_comb begin
      logic [1:0] n;
      logic       plain;
      ent      = '0;
      n        = 2'd0;
      plain    = 1'b0;
      phase_in = upd_pkg::PhIdle;
      held_in  = held_ff;

      unique case (phase_ff)
         upd_pkg::PhPct: begin
            if (b_hex) begin
               held_in  = in_byte;
               phase_in = upd_pkg::PhDigit;
            end else begin
               ent.bytes[n] = upd_pkg::ChPercent;
               n = n + 2'd1;
               plain = 1'b1;
            end
         end
         upd_pkg::PhDigit: begin
            if (b_hex) begin
               ent.bytes[n] = {upd_pkg::hex_value(held_ff), upd_pkg::hex_value(in_byte)};
               n = n + 2'd1;
            end else begin
               ent.bytes[n] = upd_pkg::ChPercent;
               ent.bytes[n + 2'd1] = held_ff;
               n = n + 2'd2;
               plain = 1'b1;
            end
         end
         default: begin
            plain = 1'b1;
         end
      endcase

      if (plain) begin
         priority if (in_byte == upd_pkg::ChPlus) begin
            ent.bytes[n] = upd_pkg::ChSpace;
            n = n + 2'd1;
         end else if (in_byte == upd_pkg::ChPercent) begin
            phase_in = upd_pkg::PhPct;
         end else begin
            ent.bytes[n] = in_byte;
            n = n + 2'd1;
         end
      end

      if (in_last) begin
         // flush a pending escape
         if (phase_in == upd_pkg::PhPct) begin
            ent.bytes[n] = upd_pkg::ChPercent;
            n = n + 2'd1;
         end else if (phase_in == upd_pkg::PhDigit) begin
            ent.bytes[n] = upd_pkg::ChPercent;
            ent.bytes[n + 2'd1] = held_in;
            n = n + 2'd2;
         end
         phase_in = upd_pkg::PhIdle;
         held_in  = 8'h00;
      end

      ent.count = n;
      ent.last  = in_last;
   end

   assign push       = accept && (ent.count != 2'd0);
   assign push_entry = ent;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= upd_pkg::PhIdle;
         held_ff  <= 8'h00;
      end else if (accept) begin
         phase_ff <= phase_in;
         held_ff  <= held_in;
      end
   end

endmodule

// ===== hdl/upd_queue.sv =====
module upd_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  upd_pkg::entry_type    push_entry,
   input  logic                  pop,
   output upd_pkg::entry_type    head,
   output upd_pkg::q_status_type q_status
);

   upd_pkg::entry_type mem_ff [upd_pkg::QDepth];

   logic [upd_pkg::QPtrW-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [upd_pkg::QFillW-1:0] fill_ff;

   assign q_status.empty = (fill_ff == '0);
   assign q_status.full  = (fill_ff == upd_pkg::QFillW'(upd_pkg::QDepth));
   assign head           = mem_ff[rd_ptr_ff];

   function automatic logic [upd_pkg::QPtrW-1:0] next_ptr(input logic [upd_pkg::QPtrW-1:0] p);
      if (p == upd_pkg::QPtrW'(upd_pkg::QDepth - 1)) begin
         return '0;
      end
      return p + 1'b1;
   endfunction

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= next_ptr(wr_ptr_ff);
         end
         if (pop) begin
            rd_ptr_ff <= next_ptr(rd_ptr_ff);
         end
         if (push && !pop) begin
            fill_ff <= fill_ff + 1'b1;
         end else if (pop && !push) begin
            fill_ff <= fill_ff - 1'b1;
         end
      end
   end

endmodule

// ===== hdl/upd_back.sv =====
module upd_back (
   input  logic                  clock,
   input  logic                  reset,
   input  upd_pkg::entry_type    head,
   input  upd_pkg::q_status_type q_status,
   output logic                  pop,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [7:0]            out_byte,
   output logic                  out_last
);

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       last_ff, last_in;
   logic [1:0] idx_ff, idx_in;
   logic       load;
   logic       final_byte;

   // output register may be refilled when empty or being taken
   assign load       = !valid_ff || out_ready;
   assign final_byte = (idx_ff == head.count - 2'd1);
   assign pop        = load && !q_status.empty && final_byte;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      last_in  = last_ff;
      idx_in   = idx_ff;
      if (load) begin
         if (q_status.empty) begin
            valid_in = 1'b0;
         end else begin
            valid_in = 1'b1;
            byte_in  = head.bytes[idx_ff];
            last_in  = head.last && final_byte;
            idx_in   = final_byte ? 2'd0 : idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   assign out_valid = valid_ff;
   assign out_byte  = byte_ff;
   assign out_last  = last_ff;

endmodule

// ===== hdl/url_percent_decoder_top.sv =====
// url percent decoder: form-style decoding of a byte stream
//
// req channel: one encoded byte per word on req_tdata, req_tlast marks the
// final byte of a string. rsp channel: one decoded byte per word on
// rsp_tdata, rsp_tlast on the final decoded byte of the string.
// '+' becomes a space, '%' with two hex digits becomes one byte, a broken
// escape passes through unchanged.
// path: an accepted byte is written into the queue, then loaded into the
// output register that drives rsp once the output side is free.
// throughput: one input word per cycle unless the queue is full; each input
// word yields 0 to 3 output words, the output register drains one word per
// cycle while rsp_tready is high, so broken escapes (up to 3 words) hold
// input once the two-entry queue between classifier and output is full.
// reset clears the escape state, the queue and the output register.
// when rsp_tready is low the output word holds, the queue fills and then
// req_tready drops.
module url_percent_decoder_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic       rsp_tlast
);

   logic                  push;
   logic                  pop;
   upd_pkg::entry_type    push_entry;
   upd_pkg::entry_type    head;
   upd_pkg::q_status_type q_status;

   upd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_byte    (req_tdata),
      .in_last    (req_tlast),
      .q_status   (q_status),
      .push       (push),
      .push_entry (push_entry)
   );

   upd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .q_status   (q_status)
   );

   upd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .q_status  (q_status),
      .pop       (pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_byte  (rsp_tdata),
      .out_last  (rsp_tlast)
   );

endmodule

// ===== hdl/upd_checker.sv =====
module upd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast
);

   // nothing comes out in the cycle after reset
   a_rsp_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid set right after reset");

   // queue is empty after reset, so input is taken at once
   a_req_ready_after_reset: assert property (@(posedge clock)
      reset |=> req_tready)
      else $error("req_tready low right after reset");

   a_rsp_valid_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp_tvalid dropped while stalled");

   a_rsp_word_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp word changed while stalled");

endmodule

bind url_percent_decoder_top upd_checker u_upd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
